// ===== hdl/gucs_pkg.sv =====
// ----------------------------------------------------------------------------
// gucs_pkg
// Shared types and constants of the grid uniform-cost search block.
// ----------------------------------------------------------------------------
package gucs_pkg;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_SEARCH = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic REG_ONLY_VORONOI = 1'b0;
	localparam logic REG_STOP_VORONOI = 1'b1;

	// neighbour offsets, in expansion order
	localparam int NB_DX [8] = '{-1, 0, 1, 0, -1, -1, 1, 1};
	localparam int NB_DY [8] = '{0, -1, 0, 1, -1, 1, -1, 1};

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CLR, S_INIT, S_SCAN, S_CHK, S_NB, S_NBCHK, S_TRD, S_TWR, S_DONE
	} state_t;

	typedef struct packed {
		logic map_write;
		logic read_start;
		logic search_start;
		logic respond;
		logic resp_read;
		logic clr_step;
		logic init_search;
		logic scan_read;
		logic scan_advance;
		logic level_next;
		logic nb_read;
		logic nb_update;
		logic nb_skip;
		logic trace_start;
		logic trace_read;
		logic trace_write;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic start_ok;
		logic is_pop;
		logic is_hit;
		logic scan_last;
		logic pushed_any;
		logic nb_inb;
		logic nb_last;
		logic nb_free;
		logic trace_zero;
	} stat_t;

endpackage

// ===== hdl/gucs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gucs_ctrl
// Sequencer: map writes, path reads, clear sweep, level scan, expansion, trace.
// ----------------------------------------------------------------------------
module gucs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       operation,
	input  gucs_pkg::stat_t  stat,
	output gucs_pkg::cmd_t   cmd,
	output logic             busy
);
	import gucs_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		logic move_on;
		move_on = 1'b0;
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op_t'(operation))
						OP_SEARCH: begin
							cmd.search_start = 1'b1;
							state_d = S_CLR;
						end
						OP_READ: begin
							cmd.read_start = 1'b1;
							state_d = S_RD;
						end
						OP_WRITE: begin
							cmd.map_write = 1'b1;
							cmd.respond = 1'b1;
						end
						OP_NONE: cmd.respond = 1'b1;
					endcase
				end
			end
			S_RD: begin
				cmd.respond = 1'b1;
				cmd.resp_read = 1'b1;
				state_d = S_IDLE;
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_d = S_INIT;
			end
			S_INIT: begin
				if (stat.start_ok) begin
					cmd.init_search = 1'b1;
					state_d = S_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				cmd.scan_read = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.is_pop && stat.is_hit) begin
					cmd.trace_start = 1'b1;
					state_d = S_TRD;
				end else if (stat.is_pop) begin
					state_d = S_NB;
				end else begin
					move_on = 1'b1;
				end
			end
			S_NB: begin
				if (stat.nb_inb) begin
					cmd.nb_read = 1'b1;
					state_d = S_NBCHK;
				end else begin
					cmd.nb_skip = 1'b1;
					move_on = stat.nb_last;
				end
			end
			S_NBCHK: begin
				cmd.nb_update = 1'b1;
				if (stat.nb_last) move_on = 1'b1;
				else state_d = S_NB;
			end
			S_TRD: begin
				if (stat.trace_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.trace_read = 1'b1;
					state_d = S_TWR;
				end
			end
			S_TWR: begin
				cmd.trace_write = 1'b1;
				state_d = S_TRD;
			end
			S_DONE: begin
				cmd.respond = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		// next cell of the scan, next level, or open list exhausted
		if (move_on) begin
			if (!stat.scan_last) begin
				cmd.scan_advance = 1'b1;
				state_d = S_SCAN;
			end else if (stat.pushed_any || (state_q == S_NBCHK && stat.nb_free)) begin
				// a push of the last neighbour lands at this very edge
				cmd.level_next = 1'b1;
				state_d = S_SCAN;
			end else begin
				state_d = S_DONE;
			end
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> state_q == S_IDLE)
		else $error("search result not followed by idle");
	a_search_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search_start |=> state_q == S_CLR)
		else $error("search did not begin with clear sweep");
	a_trace_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TWR |-> !stat.trace_zero)
		else $error("path write past start");

endmodule

// ===== hdl/gucs_dp.sv =====
// ----------------------------------------------------------------------------
// gucs_dp
// Datapath: map store, search store (closed, cost, direction), path store.
// ----------------------------------------------------------------------------
module gucs_dp #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gucs_pkg::cmd_t  cmd,
	output gucs_pkg::stat_t stat,
	input  logic [5:0]      cell_x,
	input  logic [5:0]      cell_y,
	input  logic            occupied,
	input  logic            on_voronoi,
	input  logic [5:0]      goal_x,
	input  logic [5:0]      goal_y,
	input  logic [11:0]     path_index,
	input  logic            only_voronoi_cells,
	input  logic            stop_at_any_voronoi,
	output logic            result_valid,
	output logic            found,
	output logic [11:0]     path_length,
	output logic [5:0]      step_x,
	output logic [5:0]      step_y,
	output logic            index_valid
);
	import gucs_pkg::*;

	localparam int XW = $clog2(GRID_WIDTH);
	localparam int YW = $clog2(GRID_HEIGHT);
	localparam int AW = XW + YW;
	localparam int CW = AW + 1;
	localparam int SW = CW + 4;

	// stores
	logic [1:0]    map_mem  [2**AW];
	logic [SW-1:0] srch_mem [2**AW];
	logic [AW-1:0] path_mem [2**AW];

	logic [1:0]    map_rd_q;
	logic [SW-1:0] srch_rd_q;
	logic [AW-1:0] path_rd_q;

	logic [XW-1:0] sx_q, tx_q, start_x_q;
	logic [YW-1:0] sy_q, ty_q, start_y_q;
	logic [5:0]    goal_x_q, goal_y_q;
	logic [CW-1:0] level_q, k_q, pcount_q;
	logic [AW-1:0] clr_q;
	logic [2:0]    nb_q;
	logic          pushed_q, found_q, rvalid_q;
	logic          start_ok_q;

	logic [AW-1:0] raddr, waddr, nb_addr;
	logic [SW-1:0] wdata;
	logic          we;
	logic          nb_free;
	int            nxi, nyi;
	logic [2:0]    tdir;

	assign nxi = int'(sx_q) + NB_DX[nb_q];
	assign nyi = int'(sy_q) + NB_DY[nb_q];
	assign nb_addr = {YW'(nyi), XW'(nxi)};
	assign tdir = srch_rd_q[2:0];
	assign nb_free = !map_rd_q[1] && !srch_rd_q[SW-1] && (!only_voronoi_cells || map_rd_q[0]);

	always_comb begin
		priority if (cmd.nb_read) raddr = nb_addr;
		else if (cmd.trace_read)  raddr = {ty_q, tx_q};
		else                      raddr = {sy_q, sx_q};
	end

	always_comb begin
		we = 1'b0;
		waddr = nb_addr;
		wdata = {1'b1, level_q + CW'(1), nb_q};
		priority if (cmd.clr_step) begin
			we = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (cmd.init_search) begin
			we = 1'b1;
			waddr = {start_y_q, start_x_q};
			wdata = {1'b1, CW'(0), 3'd0};
		end else if (cmd.nb_update) begin
			we = nb_free;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.map_write && int'(cell_x) < GRID_WIDTH && int'(cell_y) < GRID_HEIGHT) begin
			map_mem[{YW'(cell_y), XW'(cell_x)}] <= {occupied, on_voronoi};
		end
		map_rd_q <= map_mem[raddr];
		if (we) srch_mem[waddr] <= wdata;
		srch_rd_q <= srch_mem[raddr];
		if (cmd.trace_write) path_mem[AW'(k_q - CW'(1))] <= {ty_q, tx_q};
		path_rd_q <= path_mem[AW'(path_index)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0; sy_q <= '0; tx_q <= '0; ty_q <= '0;
			start_x_q <= '0; start_y_q <= '0; goal_x_q <= '0; goal_y_q <= '0;
			level_q <= '0; k_q <= '0; pcount_q <= '0; clr_q <= '0; nb_q <= '0;
			pushed_q <= 1'b0; found_q <= 1'b0; rvalid_q <= 1'b0; start_ok_q <= 1'b0;
			result_valid <= 1'b0; step_x <= '0; step_y <= '0; index_valid <= 1'b0;
		end else begin
			result_valid <= cmd.respond;
			if (cmd.respond) begin
				index_valid <= cmd.resp_read && rvalid_q;
				step_x <= (cmd.resp_read && rvalid_q) ? 6'(path_rd_q[XW-1:0]) : 6'd0;
				step_y <= (cmd.resp_read && rvalid_q) ? 6'(path_rd_q[AW-1:XW]) : 6'd0;
			end
			if (cmd.read_start) rvalid_q <= (32'(path_index) < 32'(pcount_q));
			if (cmd.search_start) begin
				found_q <= 1'b0;
				pcount_q <= '0;
				clr_q <= '0;
				start_ok_q <= int'(cell_x) < GRID_WIDTH && int'(cell_y) < GRID_HEIGHT;
				start_x_q <= XW'(cell_x);
				start_y_q <= YW'(cell_y);
				goal_x_q <= goal_x;
				goal_y_q <= goal_y;
			end
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.init_search || cmd.level_next) begin
				sx_q <= '0;
				sy_q <= '0;
			end
			if (cmd.init_search || cmd.level_next) pushed_q <= 1'b0;
			else if (cmd.nb_update && we) pushed_q <= 1'b1;
			if (cmd.init_search) level_q <= '0;
			if (cmd.level_next) level_q <= level_q + CW'(1);
			if (cmd.scan_advance) begin
				if (int'(sy_q) == GRID_HEIGHT - 1) begin
					sy_q <= '0;
					sx_q <= sx_q + XW'(1);
				end else begin
					sy_q <= sy_q + YW'(1);
				end
			end
			if (cmd.scan_read) nb_q <= '0;
			if (cmd.nb_skip || cmd.nb_update) nb_q <= nb_q + 3'd1;
			if (cmd.trace_start) begin
				found_q <= 1'b1;
				pcount_q <= level_q;
				k_q <= level_q;
				tx_q <= sx_q;
				ty_q <= sy_q;
			end
			if (cmd.trace_write) begin
				k_q <= k_q - CW'(1);
				tx_q <= XW'(int'(tx_q) - NB_DX[tdir]);
				ty_q <= YW'(int'(ty_q) - NB_DY[tdir]);
			end
		end
	end

	always_comb begin
		stat.clr_last   = &clr_q;
		stat.start_ok   = start_ok_q;
		stat.is_pop     = srch_rd_q[SW-1] && (srch_rd_q[SW-2:3] == level_q);
		stat.is_hit     = stop_at_any_voronoi ? map_rd_q[0]
			: (32'(sx_q) == 32'(goal_x_q) && 32'(sy_q) == 32'(goal_y_q));
		stat.scan_last  = int'(sx_q) == GRID_WIDTH - 1 && int'(sy_q) == GRID_HEIGHT - 1;
		stat.pushed_any = pushed_q;
		stat.nb_inb     = nxi >= 0 && nxi < GRID_WIDTH && nyi >= 0 && nyi < GRID_HEIGHT;
		stat.nb_last    = nb_q == 3'd7;
		stat.nb_free    = nb_free;
		stat.trace_zero = k_q == '0;
	end

	assign found = found_q;
	assign path_length = 12'(pcount_q);

endmodule

// ===== hdl/grid_uniform_cost_search_top.sv =====
// ----------------------------------------------------------------------------
// grid_uniform_cost_search_top
// Eight-neighbour uniform-cost grid search with map load and path read-back.
// ----------------------------------------------------------------------------
// Usage: drive a word on the input ports with start high; it is taken at an
// edge where busy is low. Each word gives one result, shown for one cycle
// with result_valid high; the receiver cannot stall it.
// Map write (operation 0): result in the next cycle, a new word each cycle.
// Path read (operation 2): busy while the stored step is fetched; the result
// follows in the next cycle. Search (operation 1): a clear sweep of the
// search store, a set-up step, then a level-by-level scan of the grid that
// reads and checks each cell; each expanded cell reads and updates each
// in-grid neighbour and skips each off-grid one; trace-back reads and writes
// each path step, then the done state responds; the result follows next cycle.
// found and path_length report the last search on every result.
// Registers over APB: 0x0 only_voronoi_cells, 0x4 stop_at_any_voronoi;
// pready is tied high. Reset clears the path count, found and the registers
// (stop_at_any_voronoi resets to 1); map contents are undefined until written.
// ----------------------------------------------------------------------------
module grid_uniform_cost_search_top #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [5:0]  cell_x,
	input  logic [5:0]  cell_y,
	input  logic        occupied,
	input  logic        on_voronoi,
	input  logic [5:0]  goal_x,
	input  logic [5:0]  goal_y,
	input  logic [11:0] path_index,
	output logic        result_valid,
	output logic        found,
	output logic [11:0] path_length,
	output logic [5:0]  step_x,
	output logic [5:0]  step_y,
	output logic        index_valid
);
	import gucs_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  only_vor_q, stop_vor_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			only_vor_q <= 1'b0;
			stop_vor_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_ONLY_VORONOI: only_vor_q <= pwdata[0];
				REG_STOP_VORONOI: stop_vor_q <= pwdata[0];
			endcase
		end
	end

	assign prdata = {31'd0, (paddr[2] == REG_STOP_VORONOI) ? stop_vor_q : only_vor_q};

	gucs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	gucs_dp #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.cell_x              (cell_x),
		.cell_y              (cell_y),
		.occupied            (occupied),
		.on_voronoi          (on_voronoi),
		.goal_x              (goal_x),
		.goal_y              (goal_y),
		.path_index          (path_index),
		.only_voronoi_cells  (only_vor_q),
		.stop_at_any_voronoi (stop_vor_q),
		.result_valid        (result_valid),
		.found               (found),
		.path_length         (path_length),
		.step_x              (step_x),
		.step_y              (step_y),
		.index_valid         (index_valid)
	);

endmodule
